// File: src/dertlv_pkg.sv
package dertlv_pkg;

   localparam logic       OP_HEADER      = 1'b0;
   localparam logic       OP_VALUE       = 1'b1;
   localparam logic [7:0] SHORT_FORM_MAX = 8'd127;
   localparam logic [7:0] LONG_FORM_FLAG = 8'h80;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_OVERFLOW   = 2'd1,
      ERR_NON_ASCII  = 2'd2,
      ERR_UNEXPECTED = 2'd3
   } err_type;

   // One classified item handed from the front to the back.
   typedef struct packed {
      logic [7:0]  first_byte;   // tag, value byte, or zero for an error
      logic [31:0] content_len;
      logic [2:0]  nlen;         // long-form length byte count, 0 for short form
      logic [2:0]  last_idx;     // index of the final beat of this item
      err_type     err;
      logic [31:0] written0;     // bytes_written on the first beat
   } cmd_type;

endpackage

// File: src/der_tlv_stream_encoder.sv
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  tuser operation; tdata tag, length, check, byte
// rsp_      out  rsp_tvalid/rsp_tready  tdata byte, error, offset; tlast end of item
// csr_      in   csr_we                 csr_wdata buffer capacity
//
// One input beat is taken per cycle while the command queue has room.
// A header makes 2 to 6 output beats and a value byte or an error makes one;
// the output register sends one beat per cycle while rsp_tready is high, so
// headers with long lengths fill the queue and hold req_tready low until the
// back side drains it. Each input beat is registered in the queue and then
// in the output register. Reset is synchronous and clears offset, remaining
// count, ASCII mode and the queue; capacity resets to all ones.
module der_tlv_stream_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] tag, [39:8] content_len, [40] check_ascii, [48:41] value_byte,
   // [55:49] zero
   input  logic [55:0] req_tdata,
   // [0] operation
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte, [9:8] error_code, [41:10] bytes_written, [47:42] zero
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast
);
   import dertlv_pkg::*;

   cmd_type     push_cmd;
   cmd_type     head_cmd;
   logic        q_full;
   logic        q_empty;
   logic        q_pop;
   logic [7:0]  out_byte;
   logic [1:0]  error_code;
   logic [31:0] bytes_written;

   assign req_tready = !q_full;

   dertlv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .operation   (req_tuser),
      .tag         (req_tdata[7:0]),
      .content_len (req_tdata[39:8]),
      .check_ascii (req_tdata[40]),
      .value_byte  (req_tdata[48:41]),
      .cmd         (push_cmd)
   );

   dertlv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (head_cmd),
      .empty     (q_empty)
   );

   dertlv_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd           (head_cmd),
      .cmd_valid     (!q_empty),
      .cmd_pop       (q_pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_byte      (out_byte),
      .out_last      (rsp_tlast),
      .error_code    (error_code),
      .bytes_written (bytes_written)
   );

   assign rsp_tdata = {6'd0, bytes_written, error_code, out_byte};

endmodule

// File: src/dertlv_front.sv
module dertlv_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [31:0]         csr_wdata,
   input  logic                in_valid,
   input  logic                in_ready,
   input  logic                operation,
   input  logic [7:0]          tag,
   input  logic [31:0]         content_len,
   input  logic                check_ascii,
   input  logic [7:0]          value_byte,
   output dertlv_pkg::cmd_type cmd
);
   import dertlv_pkg::*;

   logic [31:0] capacity_ff, capacity_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] vleft_ff, vleft_in;
   logic        ascii_ff, ascii_in;

   logic [2:0]  nlen;
   logic [33:0] total;
   logic [31:0] room;
   logic        hdr_ovf;
   logic        accept;

   assign accept = in_valid && in_ready;

   always_comb begin
      if (content_len > {24'd0, SHORT_FORM_MAX}) begin
         if (content_len[31:24] != 8'd0) begin
            nlen = 3'd4;
         end else if (content_len[23:16] != 8'd0) begin
            nlen = 3'd3;
         end else if (content_len[15:8] != 8'd0) begin
            nlen = 3'd2;
         end else begin
            nlen = 3'd1;
         end
      end else begin
         nlen = 3'd0;
      end
   end

   // The whole item (tag, length bytes and value bytes) must fit in the room left.
   assign total   = {2'b00, content_len} + {31'd0, nlen} + 34'd2;
   assign room    = capacity_ff - offset_ff;
   assign hdr_ovf = (offset_ff > capacity_ff) || (total > {2'b00, room});

   always_comb begin
      capacity_in = csr_we ? csr_wdata : capacity_ff;
      offset_in   = offset_ff;
      vleft_in    = vleft_ff;
      ascii_in    = ascii_ff;

      cmd.first_byte  = 8'd0;
      cmd.content_len = content_len;
      cmd.nlen        = nlen;
      cmd.last_idx    = 3'd0;
      cmd.err         = ERR_NONE;
      cmd.written0    = offset_ff;

      if (operation == OP_HEADER) begin
         if (hdr_ovf) begin
            cmd.err  = ERR_OVERFLOW;
            vleft_in = 32'd0;
         end else begin
            cmd.first_byte = tag;
            cmd.last_idx   = nlen + 3'd1;
            cmd.written0   = offset_ff + 32'd1;
            offset_in      = offset_ff + 32'd2 + {29'd0, nlen};
            vleft_in       = content_len;
            ascii_in       = check_ascii;
         end
      end else begin
         if (vleft_ff == 32'd0) begin
            cmd.err  = ERR_UNEXPECTED;
            vleft_in = 32'd0;
         end else if (ascii_ff && value_byte[7]) begin
            cmd.err  = ERR_NON_ASCII;
            vleft_in = 32'd0;
         end else if (offset_ff >= capacity_ff) begin
            cmd.err  = ERR_OVERFLOW;
            vleft_in = 32'd0;
         end else begin
            cmd.first_byte = value_byte;
            cmd.written0   = offset_ff + 32'd1;
            offset_in      = offset_ff + 32'd1;
            vleft_in       = vleft_ff - 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 32'hFFFF_FFFF;
         offset_ff   <= 32'd0;
         vleft_ff    <= 32'd0;
         ascii_ff    <= 1'b0;
      end else begin
         capacity_ff <= capacity_in;
         if (accept) begin
            offset_ff <= offset_in;
            vleft_ff  <= vleft_in;
            ascii_ff  <= ascii_in;
         end
      end
   end

endmodule

// File: src/dertlv_queue.sv
module dertlv_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dertlv_pkg::cmd_type push_data,
   output logic                full,
   input  logic                pop,
   output dertlv_pkg::cmd_type pop_data,
   output logic                empty
);
   import dertlv_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   cmd_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/dertlv_back.sv
module dertlv_back (
   input  logic                clock,
   input  logic                reset,
   input  dertlv_pkg::cmd_type cmd,
   input  logic                cmd_valid,
   output logic                cmd_pop,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [7:0]          out_byte,
   output logic                out_last,
   output logic [1:0]          error_code,
   output logic [31:0]         bytes_written
);
   import dertlv_pkg::*;

   logic [2:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [1:0]  err_ff;
   logic [31:0] written_ff, written_in;
   logic        advance;
   logic        at_last;
   logic [2:0]  sel;

   assign advance = cmd_valid && (!valid_ff || out_ready);
   assign at_last = (idx_ff == cmd.last_idx);
   assign cmd_pop = advance && at_last;

   // Length bytes go out big-endian; sel counts down from nlen to 1.
   assign sel = cmd.nlen + 3'd2 - idx_ff;

   always_comb begin
      case (idx_ff)
         3'd0: byte_in = cmd.first_byte;
         3'd1: byte_in = (cmd.nlen == 3'd0) ? cmd.content_len[7:0]
                                            : (LONG_FORM_FLAG | {5'd0, cmd.nlen});
         default: begin
            case (sel)
               3'd1:    byte_in = cmd.content_len[7:0];
               3'd2:    byte_in = cmd.content_len[15:8];
               3'd3:    byte_in = cmd.content_len[23:16];
               3'd4:    byte_in = cmd.content_len[31:24];
               default: byte_in = 8'd0;
            endcase
         end
      endcase
   end

   assign last_in    = at_last;
   assign written_in = cmd.written0 + {29'd0, idx_ff};

   always_comb begin
      if (advance) begin
         valid_in = 1'b1;
         idx_in   = at_last ? 3'd0 : idx_ff + 3'd1;
      end else begin
         valid_in = valid_ff && !out_ready;
         idx_in   = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff    <= byte_in;
         last_ff    <= last_in;
         err_ff     <= cmd.err;
         written_ff <= written_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_byte      = byte_ff;
   assign out_last      = last_ff;
   assign error_code    = err_ff;
   assign bytes_written = written_ff;

endmodule
